// ----- sv/eapg_pkg.sv -----
// ----------------------------------------------------------------------------
// eapg_pkg
// Shared types and constants of the elliptic arc point generator: angle
// formats, the series divisors and their reciprocals, and register indexes.
// ----------------------------------------------------------------------------
package eapg_pkg;

  // Angles are unsigned degrees * 256
  localparam int AngleW = 17;
  localparam int QuadW  = 15;
  localparam logic [AngleW-1:0] FullTurn     = 17'd92160;
  localparam logic [AngleW-1:0] QuarterTurn  = 17'd23040;
  localparam logic [AngleW-1:0] HalfTurn     = 17'd46080;
  localparam logic [AngleW-1:0] ThreeQuarter = 17'd69120;
  localparam logic [AngleW:0]   TwoTurns     = 18'd184320;

  // Input and register widths
  localparam int IdxW  = 12;
  localparam int SpanW = 17;
  localparam int ProdW = IdxW + SpanW;
  localparam logic [IdxW-1:0] MaxSides = 12'd4095;

  // pi * 2^40, split for two narrow multipliers
  localparam logic [41:0] PiQ40 = 42'h3243F6A8886;
  localparam logic [20:0] PiHi  = PiQ40[41:21];
  localparam logic [20:0] PiLo  = PiQ40[20:0];

  // Radian scaling: divide by 45 after dropping 20 bits. The quotient is
  // estimated from the top 32 numerator bits times 2^37 / 45, then corrected.
  localparam int RadNumW = 37;
  localparam int RadDenW = 6;
  localparam logic [RadDenW-1:0] RadDiv = 6'd45;
  localparam logic [31:0] RadRecip = 32'(64'h20_0000_0000 / 64'd45);

  // Series format: x is Q30, one is 2^30
  localparam int XW = 31;
  localparam int SW = 32;
  localparam int TW = 31;
  localparam logic [TW-1:0] OneQ30 = 31'h4000_0000;
  localparam int SinW = 18;
  localparam logic [31:0] SinRound = 32'd8192;

  localparam int SinTerms = 6;
  localparam logic [7:0] SinDiv [SinTerms] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [31:0] SinRecip [SinTerms] = '{
    32'(64'h1_0000_0000 / 64'd156),
    32'(64'h1_0000_0000 / 64'd110),
    32'(64'h1_0000_0000 / 64'd72),
    32'(64'h1_0000_0000 / 64'd42),
    32'(64'h1_0000_0000 / 64'd20),
    32'(64'h1_0000_0000 / 64'd6)
  };

  // Configuration register indexes
  typedef enum logic [2:0] {
    CfgBoxLeft   = 3'd0,
    CfgBoxBottom = 3'd1,
    CfgBoxRight  = 3'd2,
    CfgBoxTop    = 3'd3,
    CfgSideCount = 3'd4,
    CfgStartAng  = 3'd5,
    CfgArcSpan   = 3'd6
  } cfg_reg_e;

  // Control bits that travel with each item
  typedef struct packed {
    logic valid;
    logic oor;
    logic neg;
  } ctl_t;

endpackage

// ----- sv/eapg_div_pipe.sv -----
// ----------------------------------------------------------------------------
// eapg_div_pipe
// Pipelined restoring divider, one quotient bit per register stage. The
// divisor must be held steady while items are in flight; the divider does not enforce this.
// ----------------------------------------------------------------------------
module eapg_div_pipe #(
  parameter int NUM_W = 29,
  parameter int DEN_W = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  eapg_pkg::ctl_t      ctl_i,
  input  logic [NUM_W-1:0]    num_i,
  input  logic [DEN_W-1:0]    den_i,
  output eapg_pkg::ctl_t      ctl_o,
  output logic [NUM_W-1:0]    quo_o
);

  eapg_pkg::ctl_t    ctl_q [NUM_W];
  logic [DEN_W-1:0]  rem_q [NUM_W];
  logic [NUM_W-1:0]  nq_q  [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] nq_in;
    eapg_pkg::ctl_t   ctl_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num_i;
      assign ctl_in = ctl_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign nq_in  = nq_q[i-1];
      assign ctl_in = ctl_q[i-1];
    end

    // Bring down the next numerator bit and try one subtract
    assign trial = {rem_in, nq_in[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_i};
    assign diff  = trial - {1'b0, den_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[i] <= '0;
      end else if (en_i) begin
        ctl_q[i] <= ctl_in;
      end
    end

    // Shift numerator bits out and quotient bits in
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq_q[i]  <= {nq_in[NUM_W-2:0], ge};
      end
    end
  end

  assign ctl_o = ctl_q[NUM_W-1];
  assign quo_o = nq_q[NUM_W-1];

endmodule

// ----- sv/eapg_sine_lane.sv -----
// ----------------------------------------------------------------------------
// eapg_sine_lane
// Quarter-wave sine in Q1.16: degrees to Q30 radians, then a Horner series
// up to x^13 with truncating products and flooring divisions.
// ----------------------------------------------------------------------------
module eapg_sine_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  eapg_pkg::ctl_t                      ctl_i,
  input  logic [eapg_pkg::QuadW-1:0]          ang_i,
  output eapg_pkg::ctl_t                      ctl_o,
  output logic signed [eapg_pkg::SinW-1:0]    sine_o
);

  localparam int NT = eapg_pkg::SinTerms;

  // Radian product stages
  eapg_pkg::ctl_t ctl1_q, ctl2_q, ctl3_q, ctlf1_q, ctlf2_q;
  logic [35:0] ph_q, pl_q;
  logic [eapg_pkg::RadNumW-1:0] p2_q;
  logic [56:0] psum;

  // Divide by 45 stages
  eapg_pkg::ctl_t ctlr1_q, ctlr2_q, ctlr3_q;
  logic [63:0] rprod_q;
  logic [eapg_pkg::RadNumW-1:0] rp1_q;
  logic [31:0] rq0;
  logic [37:0] rqd;
  logic [37:0] rrem;
  logic [31:0] rq_q;
  logic [7:0]  rrem_q;
  logic [31:0] radq;
  logic [eapg_pkg::XW-1:0] xr_q;

  eapg_pkg::ctl_t ctl_x;
  logic [eapg_pkg::XW-1:0] x_w;

  logic [eapg_pkg::XW-1:0] x3_q;
  logic [61:0] sq_q;

  // Series term stages
  eapg_pkg::ctl_t ctla_q [NT];
  eapg_pkg::ctl_t ctlb_q [NT];
  eapg_pkg::ctl_t ctlc_q [NT];
  logic [eapg_pkg::XW-1:0] xa_q [NT];
  logic [eapg_pkg::XW-1:0] xb_q [NT];
  logic [eapg_pkg::XW-1:0] xc_q [NT];
  logic [eapg_pkg::SW-1:0] sa_q [NT];
  logic [eapg_pkg::SW-1:0] sb_q [NT];
  logic [eapg_pkg::SW-1:0] sc_q [NT];
  logic [62:0] pa_q [NT];
  logic [31:0] vb_q [NT];
  logic [63:0] qab_q [NT];
  logic [eapg_pkg::TW-1:0] tc_q [NT];

  logic [61:0] yf1_q;
  logic [31:0] ysum;
  logic [16:0] mag;
  logic signed [eapg_pkg::SinW-1:0] sine_q;

  // Multiply the angle by pi in two halves
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q <= ang_i * eapg_pkg::PiHi;
      pl_q <= ang_i * eapg_pkg::PiLo;
      p2_q <= psum[56:20];
    end
  end

  assign psum = {ph_q, 21'b0} + 57'(pl_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q  <= '0;
      ctl2_q  <= '0;
      ctlr1_q <= '0;
      ctlr2_q <= '0;
      ctlr3_q <= '0;
    end else if (en_i) begin
      ctl1_q  <= ctl_i;
      ctl2_q  <= ctl1_q;
      ctlr1_q <= ctl2_q;
      ctlr2_q <= ctlr1_q;
      ctlr3_q <= ctlr2_q;
    end
  end

  // Finish the radian scaling: reciprocal estimate, remainder, correct by
  // up to two
  assign rq0  = rprod_q[63:32];
  assign rqd  = 38'(rq0) * 38'(eapg_pkg::RadDiv);
  assign rrem = 38'(rp1_q) - rqd;

  always_comb begin
    if (rrem_q >= {1'b0, eapg_pkg::RadDiv, 1'b0}) begin
      radq = rq_q + 32'd2;
    end else if (rrem_q >= {2'b0, eapg_pkg::RadDiv}) begin
      radq = rq_q + 32'd1;
    end else begin
      radq = rq_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rprod_q <= p2_q[eapg_pkg::RadNumW-1:5] * eapg_pkg::RadRecip;
      rp1_q   <= p2_q;
      rq_q    <= rq0;
      rrem_q  <= rrem[7:0];
      xr_q    <= radq[eapg_pkg::XW-1:0];
    end
  end

  assign ctl_x = ctlr3_q;
  assign x_w   = xr_q;

  // Square x
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
    end else if (en_i) begin
      ctl3_q <= ctl_x;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x3_q <= x_w;
      sq_q <= x_w * x_w;
    end
  end

  // One Horner step per term: multiply, reciprocal, correct and subtract
  for (genvar k = 0; k < NT; k++) begin : g_term
    eapg_pkg::ctl_t          ctl_in;
    logic [eapg_pkg::XW-1:0] x_in;
    logic [eapg_pkg::SW-1:0] s_in;
    logic [eapg_pkg::TW-1:0] t_in;
    logic [31:0]             q0;
    logic [39:0]             qd;
    logic [31:0]             rem;
    logic [31:0]             qq;

    if (k == 0) begin : g_first
      assign ctl_in = ctl3_q;
      assign x_in   = x3_q;
      assign s_in   = sq_q[61:30];
      assign t_in   = eapg_pkg::OneQ30;
    end else begin : g_next
      assign ctl_in = ctlc_q[k-1];
      assign x_in   = xc_q[k-1];
      assign s_in   = sc_q[k-1];
      assign t_in   = tc_q[k-1];
    end

    assign q0  = qab_q[k][63:32];
    assign qd  = q0 * eapg_pkg::SinDiv[k];
    assign rem = vb_q[k] - qd[31:0];
    assign qq  = (rem >= 32'(eapg_pkg::SinDiv[k])) ? q0 + 32'd1 : q0;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctla_q[k] <= '0;
        ctlb_q[k] <= '0;
        ctlc_q[k] <= '0;
      end else if (en_i) begin
        ctla_q[k] <= ctl_in;
        ctlb_q[k] <= ctla_q[k];
        ctlc_q[k] <= ctlb_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        xa_q[k]  <= x_in;
        sa_q[k]  <= s_in;
        pa_q[k]  <= s_in * t_in;
        xb_q[k]  <= xa_q[k];
        sb_q[k]  <= sa_q[k];
        vb_q[k]  <= pa_q[k][61:30];
        qab_q[k] <= pa_q[k][61:30] * eapg_pkg::SinRecip[k];
        xc_q[k]  <= xb_q[k];
        sc_q[k]  <= sb_q[k];
        tc_q[k]  <= eapg_pkg::OneQ30 - qq[eapg_pkg::TW-1:0];
      end
    end
  end

  // Final product, round to Q16 and apply the sign
  assign ysum = yf1_q[61:30] + eapg_pkg::SinRound;
  assign mag  = ysum[30:14];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctlf1_q <= '0;
      ctlf2_q <= '0;
    end else if (en_i) begin
      ctlf1_q <= ctlc_q[NT-1];
      ctlf2_q <= ctlf1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yf1_q  <= xc_q[NT-1] * tc_q[NT-1];
      sine_q <= ctlf1_q.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  assign ctl_o  = ctlf2_q;
  assign sine_o = sine_q;

endmodule

// ----- sv/eapg_vertex.sv -----
// ----------------------------------------------------------------------------
// eapg_vertex
// Places one coordinate: centre plus sine times half extent, rounded half to
// even and saturated; zero for an index past the end.
// ----------------------------------------------------------------------------
module eapg_vertex #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  eapg_pkg::ctl_t                      ctl_i,
  input  logic signed [COORD_BITS-1:0]        lo_i,
  input  logic signed [COORD_BITS-1:0]        hi_i,
  input  logic signed [eapg_pkg::SinW-1:0]    sine_i,
  output eapg_pkg::ctl_t                      ctl_o,
  output logic signed [COORD_BITS-1:0]        coord_o
);

  localparam int SumW = COORD_BITS + 1;
  localparam int MulW = eapg_pkg::SinW + SumW;
  localparam int NW   = COORD_BITS + 20;
  localparam int FlW  = NW - 17;
  localparam logic signed [FlW-1:0] CoordMax = FlW'((1 << (COORD_BITS - 1)) - 1);
  localparam logic signed [FlW-1:0] CoordMin = -CoordMax - FlW'(1);

  eapg_pkg::ctl_t ctl1_q, ctl2_q, ctl3_q;
  logic signed [SumW-1:0] sum_w, diff_w, sum_q;
  logic signed [MulW-1:0] m_q;
  logic signed [NW-1:0]   n_w;
  logic signed [FlW-1:0]  fl_w, flr_q;
  logic [16:0]            rem_w;
  logic                   rnd_w;
  logic signed [COORD_BITS-1:0] coord_q;

  assign sum_w  = SumW'(lo_i) + SumW'(hi_i);
  assign diff_w = SumW'(hi_i) - SumW'(lo_i);

  // Exact numerator, then floor and remainder by 2^17
  assign n_w   = (NW'(sum_q) <<< 16) + NW'(m_q);
  assign fl_w  = $signed(n_w[NW-1:17]);
  assign rem_w = n_w[16:0];
  assign rnd_w = (rem_w > 17'h10000) || ((rem_w == 17'h10000) && fl_w[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
    end
  end

  // Multiply, round, then saturate
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_w;
      m_q   <= sine_i * diff_w;
      flr_q <= fl_w + FlW'(rnd_w);
      if (ctl2_q.oor) begin
        coord_q <= '0;
      end else if (flr_q > CoordMax) begin
        coord_q <= CoordMax[COORD_BITS-1:0];
      end else if (flr_q < CoordMin) begin
        coord_q <= CoordMin[COORD_BITS-1:0];
      end else begin
        coord_q <= flr_q[COORD_BITS-1:0];
      end
    end
  end

  assign ctl_o   = ctl3_q;
  assign coord_o = coord_q;

endmodule

// ----- sv/elliptic_arc_point_generator.sv -----
// ----------------------------------------------------------------------------
// elliptic_arc_point_generator
// Returns one vertex of a polygonal arc on the ellipse inscribed in a box.
// ----------------------------------------------------------------------------
// Takes one point index per clock and returns one vertex per clock, in order,
// as long as the output buffer is not full. The pipeline includes the bit-serial
// divider pipeline for index * span / sides (29 stages), the three-stage
// reciprocal divide by 45 of the radian scaling and the six three-stage terms
// of the sine series; sine and cosine run in parallel lanes.
// A two-entry output buffer lets the pipeline keep accepting while one result
// waits; input stalls only once that buffer is full. Configuration must be
// written only while no item is in flight; the block does not enforce this.
module elliptic_arc_point_generator #(
  parameter int COORD_BITS = 16,
  localparam int CfgW = (COORD_BITS > 17) ? COORD_BITS : 17
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [CfgW-1:0]               cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [eapg_pkg::IdxW-1:0]     point_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_BITS-1:0]  point_x_o,
  output logic signed [COORD_BITS-1:0]  point_y_o,
  output logic                          out_of_range_o
);

  // Fold an angle below one turn into a quarter: {negate, quarter angle}
  function automatic logic [eapg_pkg::QuadW:0] fold(input logic [eapg_pkg::AngleW-1:0] r);
    logic [eapg_pkg::AngleW-1:0] f;
    logic [eapg_pkg::AngleW-1:0] g;
    logic                        odd;
    if (r >= eapg_pkg::ThreeQuarter) begin
      f   = r - eapg_pkg::ThreeQuarter;
      odd = 1'b1;
    end else if (r >= eapg_pkg::HalfTurn) begin
      f   = r - eapg_pkg::HalfTurn;
      odd = 1'b0;
    end else if (r >= eapg_pkg::QuarterTurn) begin
      f   = r - eapg_pkg::QuarterTurn;
      odd = 1'b1;
    end else begin
      f   = r;
      odd = 1'b0;
    end
    g = odd ? eapg_pkg::QuarterTurn - f : f;
    return {r >= eapg_pkg::HalfTurn, g[eapg_pkg::QuadW-1:0]};
  endfunction

  // Configuration registers
  logic signed [COORD_BITS-1:0]  box_left_q, box_bottom_q, box_right_q, box_top_q;
  logic [eapg_pkg::IdxW-1:0]     side_count_q;
  logic [eapg_pkg::AngleW-1:0]   start_angle_q;
  logic [eapg_pkg::SpanW-1:0]    arc_span_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_left_q    <= '0;
      box_bottom_q  <= '0;
      box_right_q   <= COORD_BITS'(64);
      box_top_q     <= COORD_BITS'(64);
      side_count_q  <= 12'd8;
      start_angle_q <= '0;
      arc_span_q    <= eapg_pkg::FullTurn;
    end else if (cfg_we_i) begin
      case (eapg_pkg::cfg_reg_e'(cfg_idx_i))
        eapg_pkg::CfgBoxLeft:   box_left_q    <= cfg_data_i[COORD_BITS-1:0];
        eapg_pkg::CfgBoxBottom: box_bottom_q  <= cfg_data_i[COORD_BITS-1:0];
        eapg_pkg::CfgBoxRight:  box_right_q   <= cfg_data_i[COORD_BITS-1:0];
        eapg_pkg::CfgBoxTop:    box_top_q     <= cfg_data_i[COORD_BITS-1:0];
        eapg_pkg::CfgSideCount: side_count_q  <= cfg_data_i[eapg_pkg::IdxW-1:0];
        eapg_pkg::CfgStartAng:  start_angle_q <= cfg_data_i[eapg_pkg::AngleW-1:0];
        eapg_pkg::CfgArcSpan:   arc_span_q    <= cfg_data_i[eapg_pkg::SpanW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advances whenever the skid entry is free
  logic adv;
  logic skid_valid_q;
  logic in_xfer;

  assign adv        = !skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Index check and closing-point wrap
  logic [eapg_pkg::IdxW-1:0] sides;
  logic                      idx_oor;
  logic                      idx_wrap;

  always_comb begin
    if (side_count_q == '0) begin
      sides = 12'd1;
    end else if (side_count_q > eapg_pkg::MaxSides) begin
      sides = eapg_pkg::MaxSides;
    end else begin
      sides = side_count_q;
    end
  end

  assign idx_oor  = point_index_i > sides;
  assign idx_wrap = (arc_span_q == eapg_pkg::FullTurn) && (point_index_i == sides);

  eapg_pkg::ctl_t ctl0_q, ctl1_q, ctl2_q, ctls3_q, ctlc3_q;
  logic [eapg_pkg::IdxW-1:0]   idx0_q;
  logic [eapg_pkg::ProdW-1:0]  prod1_q;
  logic [eapg_pkg::AngleW-1:0] ang2_q;
  logic [eapg_pkg::QuadW-1:0]  fs3_q, fc3_q;

  eapg_pkg::ctl_t ctl_d;
  logic [eapg_pkg::ProdW-1:0] quo_d;

  logic [eapg_pkg::AngleW:0]   asum;
  logic [eapg_pkg::AngleW-1:0] ang_red;
  logic [eapg_pkg::AngleW:0]   csum;
  logic [eapg_pkg::AngleW-1:0] cang;
  logic [eapg_pkg::QuadW:0]    sfold, cfold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q  <= '0;
      ctl1_q  <= '0;
      ctl2_q  <= '0;
      ctls3_q <= '0;
      ctlc3_q <= '0;
    end else if (adv) begin
      ctl0_q  <= '{valid: in_xfer, oor: idx_oor, neg: 1'b0};
      ctl1_q  <= ctl0_q;
      ctl2_q  <= ctl_d;
      ctls3_q <= '{valid: ctl2_q.valid, oor: ctl2_q.oor, neg: sfold[eapg_pkg::QuadW]};
      ctlc3_q <= '{valid: ctl2_q.valid, oor: ctl2_q.oor, neg: cfold[eapg_pkg::QuadW]};
    end
  end

  // Reduce the start plus step angle below one turn
  assign asum = {1'b0, start_angle_q} + {1'b0, quo_d[eapg_pkg::AngleW-1:0]};

  always_comb begin
    if (asum >= eapg_pkg::TwoTurns) begin
      ang_red = eapg_pkg::AngleW'(asum - eapg_pkg::TwoTurns);
    end else if (asum >= {1'b0, eapg_pkg::FullTurn}) begin
      ang_red = eapg_pkg::AngleW'(asum - {1'b0, eapg_pkg::FullTurn});
    end else begin
      ang_red = asum[eapg_pkg::AngleW-1:0];
    end
  end

  // Cosine is the sine a quarter turn on
  assign csum  = {1'b0, ang2_q} + {1'b0, eapg_pkg::QuarterTurn};
  assign cang  = (csum >= {1'b0, eapg_pkg::FullTurn}) ?
                 eapg_pkg::AngleW'(csum - {1'b0, eapg_pkg::FullTurn}) :
                 csum[eapg_pkg::AngleW-1:0];
  assign sfold = fold(ang2_q);
  assign cfold = fold(cang);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      idx0_q  <= (idx_oor || idx_wrap) ? '0 : point_index_i;
      prod1_q <= idx0_q * arc_span_q;
      ang2_q  <= ang_red;
      fs3_q   <= sfold[eapg_pkg::QuadW-1:0];
      fc3_q   <= cfold[eapg_pkg::QuadW-1:0];
    end
  end

  // Step angle: index * span / sides
  eapg_div_pipe #(
    .NUM_W (eapg_pkg::ProdW),
    .DEN_W (eapg_pkg::IdxW)
  ) u_step_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .ctl_i  (ctl1_q),
    .num_i  (prod1_q),
    .den_i  (sides),
    .ctl_o  (ctl_d),
    .quo_o  (quo_d)
  );

  // Sine and cosine lanes
  eapg_pkg::ctl_t ctl_s, ctl_c;
  logic signed [eapg_pkg::SinW-1:0] sine_s, sine_c;

  eapg_sine_lane u_sin_lane (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .ctl_i  (ctls3_q),
    .ang_i  (fs3_q),
    .ctl_o  (ctl_s),
    .sine_o (sine_s)
  );

  eapg_sine_lane u_cos_lane (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .ctl_i  (ctlc3_q),
    .ang_i  (fc3_q),
    .ctl_o  (ctl_c),
    .sine_o (sine_c)
  );

  // Place x and y
  eapg_pkg::ctl_t ctl_vx, ctl_vy;
  logic signed [COORD_BITS-1:0] vx, vy;

  eapg_vertex #(.COORD_BITS(COORD_BITS)) u_vertex_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .ctl_i   (ctl_s),
    .lo_i    (box_left_q),
    .hi_i    (box_right_q),
    .sine_i  (sine_s),
    .ctl_o   (ctl_vx),
    .coord_o (vx)
  );

  eapg_vertex #(.COORD_BITS(COORD_BITS)) u_vertex_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .ctl_i   (ctl_c),
    .lo_i    (box_bottom_q),
    .hi_i    (box_top_q),
    .sine_i  (sine_c),
    .ctl_o   (ctl_vy),
    .coord_o (vy)
  );

  // Output register with one skid entry
  logic out_valid_q, out_oor_q, skid_oor_q, out_take;
  logic signed [COORD_BITS-1:0] out_x_q, out_y_q, skid_x_q, skid_y_q;

  assign out_take = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (out_take) begin
      out_valid_q <= ctl_vx.valid;
    end else if (ctl_vx.valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_x_q   <= skid_x_q;
        out_y_q   <= skid_y_q;
        out_oor_q <= skid_oor_q;
      end
    end else if (out_take) begin
      out_x_q   <= vx;
      out_y_q   <= vy;
      out_oor_q <= ctl_vx.oor;
    end else begin
      skid_x_q   <= vx;
      skid_y_q   <= vy;
      skid_oor_q <= ctl_vx.oor;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign point_x_o      = out_x_q;
  assign point_y_o      = out_y_q;
  assign out_of_range_o = out_oor_q;

`ifndef SYNTHESIS
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_vx.valid == ctl_vy.valid) && (ctl_vx.oor == ctl_vy.oor))
    else $error("x and y lanes out of step");

  a_sine_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_s.valid |-> (sine_s <= 18'sd65536) && (sine_s >= -18'sd65536))
    else $error("sine lane result out of range");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> (point_x_o == '0) && (point_y_o == '0))
    else $error("out-of-range vertex with nonzero coordinates");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid entry filled while output was free");
`endif

endmodule
